@@ hw/rtl/als_pkg.sv @@
package als_pkg;

  // default sizes of the pixel store and of one pixel on the line
  localparam int MAX_PIXELS_DEF     = 256;
  localparam int BITS_PER_PIXEL_DEF = 24;

  // field widths
  localparam int COLOR_W  = 24;
  localparam int COUNT_W  = 9;
  localparam int TICK_W   = 16;
  localparam int GAP_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_COUNT = 3'd0,
    REG_BIT_PERIOD  = 3'd1,
    REG_ONE_HIGH    = 3'd2,
    REG_ZERO_HIGH   = 3'd3,
    REG_RESET_BITS  = 3'd4
  } reg_idx_t;

  // request kinds
  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_FILL  = 3'd1,
    MODE_START = 3'd2,
    MODE_TICK  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  // link phase as reported in link_status
  typedef enum logic [1:0] {
    PHASE_READY  = 2'd0,
    PHASE_PIXELS = 2'd1,
    PHASE_GAP    = 2'd2
  } phase_t;

  // register bank contents handed to the controller
  typedef struct packed {
    logic [COUNT_W-1:0] pixel_count;
    logic [TICK_W-1:0]  bit_period_ticks;
    logic [TICK_W-1:0]  one_high_ticks;
    logic [TICK_W-1:0]  zero_high_ticks;
    logic [GAP_W-1:0]   reset_bits;
  } cfg_t;

endpackage

@@ hw/rtl/als_ram.sv @@
module als_ram import als_pkg::*; #(
  parameter int WIDTH = COLOR_W,
  parameter int DEPTH = MAX_PIXELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/als_cfg.sv @@
module als_cfg import als_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  // register bank, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count      <= COUNT_W'(1);
      cfg.bit_period_ticks <= TICK_W'(89);
      cfg.one_high_ticks   <= TICK_W'(58);
      cfg.zero_high_ticks  <= TICK_W'(29);
      cfg.reset_bits       <= GAP_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_COUNT: cfg.pixel_count      <= cfg_data[COUNT_W-1:0];
        REG_BIT_PERIOD:  cfg.bit_period_ticks <= cfg_data[TICK_W-1:0];
        REG_ONE_HIGH:    cfg.one_high_ticks   <= cfg_data[TICK_W-1:0];
        REG_ZERO_HIGH:   cfg.zero_high_ticks  <= cfg_data[TICK_W-1:0];
        REG_RESET_BITS:  cfg.reset_bits       <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/als_ctrl.sv @@
module als_ctrl import als_pkg::*; #(
  parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
  parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF,
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  // request side
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,
  input  logic [2:0]         s_tuser,
  // result side
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  // pixel store port
  output logic               ram_we,
  output logic [AW-1:0]      ram_addr,
  output logic [COLOR_W-1:0] ram_wdata,
  input  logic [COLOR_W-1:0] ram_rdata
);

  localparam int CW  = $clog2(MAX_PIXELS + 1);
  localparam int BPW = $clog2(BITS_PER_PIXEL);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t             state;
  phase_t             phase;
  logic [CW-1:0]      pixel_pointer;
  logic [BPW-1:0]     bit_pointer;
  logic [TICK_W-1:0]  tick_counter;
  logic [GAP_W-1:0]   gap_counter;
  logic [COLOR_W-1:0] shift_word;
  logic [CW-1:0]      fill_pointer;
  logic [COLOR_W-1:0] fill_color;
  logic               rd_ok;

  // result register
  logic               out_line;
  logic [1:0]         out_status;
  logic               out_acc;
  logic [COLOR_W-1:0] out_rd;

  // request decode
  logic               accept;
  mode_t              mode;
  logic [7:0]         idx;
  logic [COLOR_W-1:0] color;
  logic               idx_ok;
  logic [CW-1:0]      eff_count;
  logic [31:0]        pc32;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign mode     = mode_t'(s_tuser);
  assign idx      = s_tdata[7:0];
  // stored as green, red, blue from the top byte down
  assign color    = {s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]};
  assign idx_ok   = 32'(idx) < 32'(MAX_PIXELS);

  // pixel count clamped to one..MAX_PIXELS
  assign pc32 = 32'(cfg.pixel_count);
  always_comb begin
    if (pc32 == 32'd0) begin
      eff_count = CW'(1);
    end else if (pc32 > 32'(MAX_PIXELS)) begin
      eff_count = CW'(MAX_PIXELS);
    end else begin
      eff_count = CW'(pc32);
    end
  end

  // tick engine: next waveform state for one tick
  logic [CW-1:0]      pp_inc;
  logic [TICK_W-1:0]  t_high;
  logic               t_line;
  logic               t_end;
  logic               t_last_bit;
  logic               t_last_pix;
  logic               t_gap_done;
  phase_t             tk_phase;
  logic [TICK_W-1:0]  tk_tick;
  logic [BPW-1:0]     tk_bit;
  logic [CW-1:0]      tk_pp;
  logic [GAP_W-1:0]   tk_gap;
  logic [COLOR_W-1:0] tk_shift;
  logic               tk_load;

  assign pp_inc     = pixel_pointer + CW'(1);
  assign t_high     = shift_word[COLOR_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign t_line     = (phase == PHASE_PIXELS) && (tick_counter < t_high);
  assign t_end      = tick_counter >= cfg.bit_period_ticks;
  assign t_last_bit = bit_pointer == BPW'(BITS_PER_PIXEL - 1);
  assign t_last_pix = pp_inc >= eff_count;
  assign t_gap_done = ({1'b0, gap_counter} + (GAP_W+1)'(1)) >= {1'b0, cfg.reset_bits};

  always_comb begin
    tk_phase = phase;
    tk_tick  = tick_counter;
    tk_bit   = bit_pointer;
    tk_pp    = pixel_pointer;
    tk_gap   = gap_counter;
    tk_shift = shift_word;
    tk_load  = 1'b0;
    if (phase != PHASE_READY) begin
      tk_tick = t_end ? '0 : tick_counter + TICK_W'(1);
      if (t_end) begin
        if (phase == PHASE_PIXELS) begin
          tk_shift = {shift_word[COLOR_W-2:0], 1'b0};
          if (t_last_bit) begin
            tk_pp  = pp_inc;
            tk_bit = '0;
            if (t_last_pix) begin
              tk_phase = PHASE_GAP;
              tk_gap   = '0;
            end else begin
              tk_load = 1'b1;
            end
          end else begin
            tk_bit = bit_pointer + BPW'(1);
          end
        end else begin
          if (t_gap_done) begin
            tk_phase = PHASE_READY;
            tk_pp    = '0;
            tk_gap   = '0;
          end else begin
            tk_gap = gap_counter + GAP_W'(1);
          end
        end
      end
    end
  end

  // store port: clearing pass, fill sweep, or the access of the item taken now
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = fill_pointer[AW-1:0];
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = fill_pointer[AW-1:0];
        ram_wdata = fill_color;
      end
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_WRITE: begin
              ram_we    = idx_ok;
              ram_addr  = AW'(idx);
              ram_wdata = color;
            end
            MODE_READ:  ram_addr = AW'(idx);
            MODE_TICK:  ram_addr = pp_inc[AW-1:0];
            default:    ram_addr = '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  // sequencer and link state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      phase         <= PHASE_READY;
      pixel_pointer <= '0;
      bit_pointer   <= '0;
      tick_counter  <= '0;
      gap_counter   <= '0;
      shift_word    <= '0;
      fill_pointer  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (fill_pointer == CW'(MAX_PIXELS - 1)) begin
            fill_pointer <= '0;
            state        <= ST_IDLE;
          end else begin
            fill_pointer <= fill_pointer + CW'(1);
          end
        end
        ST_FILL: begin
          if ((fill_pointer + CW'(1)) >= eff_count) begin
            fill_pointer <= '0;
            state        <= ST_IDLE;
          end else begin
            fill_pointer <= fill_pointer + CW'(1);
          end
        end
        ST_LOAD: begin
          shift_word <= ram_rdata;
          state      <= ST_IDLE;
        end
        ST_READ: begin
          out_rd   <= rd_ok ? ram_rdata : '0;
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            out_line   <= 1'b0;
            out_status <= phase;
            out_acc    <= 1'b1;
            out_rd     <= '0;
            m_tvalid   <= 1'b1;
            case (mode)
              MODE_WRITE: ;
              MODE_FILL: begin
                fill_color <= color;
                state      <= ST_FILL;
              end
              MODE_START: begin
                if (phase == PHASE_READY) begin
                  phase         <= PHASE_PIXELS;
                  out_status    <= PHASE_PIXELS;
                  pixel_pointer <= '0;
                  bit_pointer   <= '0;
                  tick_counter  <= '0;
                  gap_counter   <= '0;
                  state         <= ST_LOAD;
                end else begin
                  out_acc <= 1'b0;
                end
              end
              MODE_TICK: begin
                out_line      <= t_line;
                out_status    <= tk_phase;
                phase         <= tk_phase;
                tick_counter  <= tk_tick;
                bit_pointer   <= tk_bit;
                pixel_pointer <= tk_pp;
                gap_counter   <= tk_gap;
                shift_word    <= tk_shift;
                if (tk_load) begin
                  state <= ST_LOAD;
                end
              end
              MODE_READ: begin
                rd_ok    <= idx_ok;
                m_tvalid <= 1'b0;
                state    <= ST_READ;
              end
              default: out_acc <= 1'b0;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result layout, from the top bit down
  assign m_tdata = {4'b0, out_rd[7:0], out_rd[23:16], out_rd[15:8],
                    out_acc, out_status, out_line};

endmodule

@@ hw/rtl/addressable_led_serializer_top.sv @@
// One-wire addressable LED serializer with a pixel color store.
// Requests enter on the s_ channel (tuser = kind, tdata = pixel index and
// color); every request returns exactly one item on the m_ channel with the
// line level for that tick, the link phase, the accept flag and read-back color.
// Registers are written through the cfg_ channel (index, data), always ready.
// Write pixel, plain tick, rejected start and unknown kinds are done when taken;
// start and a tick that begins a new pixel pass through a load state, and a read
// through a read state, as the pixel store is a single-port RAM with registered
// read; a fill sweeps the pixels in use, one store write each cycle.
// The result of a request that is done when taken goes straight into the output register.
// After reset the store is cleared, one entry a cycle, while s_tready stays
// low; registers return to their defaults at once.
// One output register holds a finished result; a new request is taken in a
// cycle where that register is empty or is being taken. If the receiver
// stalls, the result holds and no further request is taken.
module addressable_led_serializer_top import als_pkg::*; #(
  parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
  parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // pixel_index, red, green, blue
  input  logic [2:0]            s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // data_line, link_status, accepted,
                                           // read_red, read_green, read_blue
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  cfg_t               cfg;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] ram_rdata;

  // register bank
  als_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pixel store
  als_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // request sequencer and waveform engine
  als_ctrl #(
    .MAX_PIXELS     (MAX_PIXELS),
    .BITS_PER_PIXEL (BITS_PER_PIXEL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

endmodule
